// ===== hdl/pnla_pkg.sv =====
package pnla_pkg;

    // Field and register widths
    localparam int COST_W    = 32;
    localparam int LABEL_W   = 10;
    localparam int NODE_W    = 12;
    localparam int CHG_W     = 13;
    localparam int LCNT_W    = 11;
    localparam int NCNT_W    = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [LCNT_W-1:0]  RST_LABEL_COUNT = LCNT_W'(27);
    localparam logic [NCNT_W-1:0]  RST_NODE_COUNT  = NCNT_W'(1);
    localparam logic [LABEL_W-1:0] RST_INIT_LABEL  = LABEL_W'(13);

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LABEL_COUNT = 2'd0,
        CFG_NODE_COUNT  = 2'd1,
        CFG_INIT_LABEL  = 2'd2
    } t_cfg_idx;

    // One result transaction
    typedef struct packed {
        logic [NODE_W-1:0]  node_id;
        logic [LABEL_W-1:0] best_label;
        logic               changed;
        logic [CHG_W-1:0]   change_count;
        logic               sweep_done;
    } t_result;

endpackage

// ===== hdl/pnla_ram.sv =====
module pnla_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/per_node_label_argmax.sv =====
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  --------------------------------------
// cfg       in         i_cfg_we                      i_cfg_idx, i_cfg_wdata
// cost      in         i_in_valid / o_in_ready       i_cost
// result    out        o_out_valid / i_out_ready     o_node_id, o_best_label, o_changed,
//                                                    o_change_count, o_sweep_done
//
// One cost transaction per cycle while o_in_ready is high. A node's result passes the
// write-back stage and the result queue before it is valid on the outputs; the label store
// is read as its last label is taken, compare and write back take the following cycle.
// Reset is synchronous; after reset and each initial_label write the label store is cleared
// at one entry a cycle over all MAX_NODES entries, with o_in_ready low meanwhile. Results
// queue in a four-entry buffer; input waits while it and write-back hold three or more.
module per_node_label_argmax #(
    parameter int MAX_LABELS = 1024,
    parameter int MAX_NODES  = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [pnla_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pnla_pkg::CFG_W-1:0]             i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [pnla_pkg::COST_W-1:0]     i_cost,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [pnla_pkg::NODE_W-1:0]            o_node_id,
    output logic [pnla_pkg::LABEL_W-1:0]           o_best_label,
    output logic                                   o_changed,
    output logic [pnla_pkg::CHG_W-1:0]             o_change_count,
    output logic                                   o_sweep_done
);
    import pnla_pkg::*;

    localparam int LPOS_W = $clog2(MAX_LABELS);
    localparam int LCMP_W = (LPOS_W + 1 > LCNT_W) ? LPOS_W + 1 : LCNT_W;
    localparam int NPOS_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCMP_W = (NPOS_W + 1 > NCNT_W) ? NPOS_W + 1 : NCNT_W;
    localparam logic [LCMP_W-1:0] MAX_LBL_C = LCMP_W'(MAX_LABELS);
    localparam logic [NCMP_W-1:0] MAX_NODE_C = NCMP_W'(MAX_NODES);
    localparam logic [NPOS_W-1:0] LAST_NODE = NPOS_W'(MAX_NODES - 1);
    localparam logic [FIFO_PTR_W:0] FIFO_ROOM = (FIFO_PTR_W + 1)'(FIFO_DEPTH - 2);

    // Configuration registers
    logic [LCNT_W-1:0]  r_label_count;
    logic [NCNT_W-1:0]  r_node_count;
    logic [LABEL_W-1:0] r_init_label;
    logic               cfg_init_wr;

    // Store clearing
    logic               r_clr_active;
    logic [NPOS_W-1:0]  r_clr_addr;

    // Accept stage
    logic signed [COST_W-1:0] r_best_score;
    logic [LPOS_W-1:0]  r_best_idx;
    logic [LPOS_W-1:0]  r_label_pos;
    logic [NPOS_W-1:0]  r_node_pos;
    logic [LCMP_W-1:0]  lc_ext;
    logic [LCMP_W-1:0]  labels_eff;
    logic [LCMP_W-1:0]  pos_next;
    logic [NCMP_W-1:0]  nc_ext;
    logic [NCMP_W-1:0]  nodes_eff;
    logic [NCMP_W-1:0]  node_next;
    logic               last_lbl;
    logic               sweep_end;
    logic               take_best;
    logic [LPOS_W-1:0]  winner_now;
    logic               in_acc;
    logic               fin;

    // Write-back stage
    logic               r_s2_valid;
    logic [LABEL_W-1:0] r_s2_winner;
    logic [NPOS_W-1:0]  r_s2_addr;
    logic [NODE_W-1:0]  r_s2_node;
    logic               r_s2_done;
    logic               r_s2_fwd;
    logic [LABEL_W-1:0] r_s2_fwd_lbl;
    logic [LABEL_W-1:0] ram_rdata;
    logic [LABEL_W-1:0] prev_lbl;
    logic               diff;
    logic [CHG_W-1:0]   chg_inc;
    logic [CHG_W-1:0]   r_changes;
    t_result            s2_res;

    // Label store ports
    logic               ram_we;
    logic [NPOS_W-1:0]  ram_waddr;
    logic [LABEL_W-1:0] ram_wdata;

    // Result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_cnt;
    logic [FIFO_PTR_W:0]   occupancy;
    logic                  push;
    logic                  pop;
    t_result               head;

    // Register writes
    assign cfg_init_wr = i_cfg_we && (i_cfg_idx == CFG_INIT_LABEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_count <= RST_LABEL_COUNT;
            r_node_count  <= RST_NODE_COUNT;
            r_init_label  <= RST_INIT_LABEL;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LABEL_COUNT: r_label_count <= i_cfg_wdata[LCNT_W-1:0];
                CFG_NODE_COUNT:  r_node_count  <= i_cfg_wdata[NCNT_W-1:0];
                CFG_INIT_LABEL:  r_init_label  <= i_cfg_wdata[LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clearing sweep over the label store, restarted by an initial_label write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (cfg_init_wr) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == LAST_NODE) begin
                r_clr_active <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Effective counts: zero reads as one, large values saturate
    always_comb begin
        lc_ext = LCMP_W'(r_label_count);
        if (lc_ext == '0) begin
            labels_eff = LCMP_W'(1);
        end else if (lc_ext > MAX_LBL_C) begin
            labels_eff = MAX_LBL_C;
        end else begin
            labels_eff = lc_ext;
        end
        nc_ext = NCMP_W'(r_node_count);
        if (nc_ext == '0) begin
            nodes_eff = NCMP_W'(1);
        end else if (nc_ext > MAX_NODE_C) begin
            nodes_eff = MAX_NODE_C;
        end else begin
            nodes_eff = nc_ext;
        end
    end

    // Running maximum; earlier label wins a tie
    assign pos_next   = LCMP_W'(r_label_pos) + LCMP_W'(1);
    assign node_next  = NCMP_W'(r_node_pos) + NCMP_W'(1);
    assign last_lbl   = pos_next >= labels_eff;
    assign sweep_end  = node_next >= nodes_eff;
    assign take_best  = (r_label_pos == '0) || (i_cost > r_best_score);
    assign winner_now = take_best ? r_label_pos : r_best_idx;
    assign in_acc     = i_in_valid && o_in_ready;
    assign fin        = in_acc && last_lbl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score <= '0;
            r_best_idx   <= '0;
            r_label_pos  <= '0;
            r_node_pos   <= '0;
            r_s2_valid   <= 1'b0;
        end else begin
            r_s2_valid <= fin;
            if (in_acc) begin
                if (take_best) begin
                    r_best_score <= i_cost;
                    r_best_idx   <= r_label_pos;
                end
                if (last_lbl) begin
                    r_label_pos <= '0;
                    if (sweep_end) begin
                        r_node_pos <= '0;
                    end else begin
                        r_node_pos <= r_node_pos + 1'b1;
                    end
                end else begin
                    r_label_pos <= LPOS_W'(pos_next);
                end
            end
        end
    end

    // Node close: capture winner and note a write-back to the same entry this cycle
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_s2_winner  <= LABEL_W'(winner_now);
            r_s2_addr    <= r_node_pos;
            r_s2_node    <= NODE_W'(r_node_pos);
            r_s2_done    <= sweep_end;
            r_s2_fwd     <= r_s2_valid && (r_s2_addr == r_node_pos);
            r_s2_fwd_lbl <= r_s2_winner;
        end
    end

    // Label store: clearing sweep or write-back
    assign ram_we    = r_clr_active || r_s2_valid;
    assign ram_waddr = r_clr_active ? r_clr_addr : r_s2_addr;
    assign ram_wdata = r_clr_active ? r_init_label : r_s2_winner;

    pnla_ram #(
        .WIDTH  (LABEL_W),
        .DEPTH  (MAX_NODES),
        .ADDR_W (NPOS_W)
    ) u_label_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (fin),
        .i_raddr (r_node_pos),
        .o_rdata (ram_rdata)
    );

    // Compare with stored label and count changes
    assign prev_lbl = r_s2_fwd ? r_s2_fwd_lbl : ram_rdata;
    assign diff     = prev_lbl != r_s2_winner;
    assign chg_inc  = r_changes + CHG_W'(diff);

    always_comb begin
        s2_res.node_id      = r_s2_node;
        s2_res.best_label   = r_s2_winner;
        s2_res.changed      = diff;
        s2_res.change_count = chg_inc;
        s2_res.sweep_done   = r_s2_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_changes <= '0;
        end else if (r_s2_valid) begin
            r_changes <= r_s2_done ? '0 : chg_inc;
        end
    end

    // Result queue
    assign push      = r_s2_valid;
    assign pop       = o_out_valid && i_out_ready;
    assign occupancy = r_cnt + (FIFO_PTR_W + 1)'(r_s2_valid);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= s2_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Ports
    assign o_in_ready     = !r_clr_active && (occupancy <= FIFO_ROOM);
    assign o_out_valid    = r_cnt != '0;
    assign head           = r_fifo[r_rd_ptr];
    assign o_node_id      = head.node_id;
    assign o_best_label   = head.best_label;
    assign o_changed      = head.changed;
    assign o_change_count = head.change_count;
    assign o_sweep_done   = head.sweep_done;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_PTR_W + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_fwd |-> $past(r_s2_valid))
        else $error("label forwarded without a preceding write-back");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_clr_active && !o_in_ready)
        else $error("label store clearing not started after reset");
`endif

endmodule
